// ----- rtl/core/vdpc_pkg.sv -----
// Shared types and constants for the vertex-disjoint path counter.
// Used by vdpc_ctrl, vdpc_dp and vertex_disjoint_path_count_top; depends on nothing.
`default_nettype none

package vdpc_pkg;

  // Field widths fixed by the interface
  localparam int CITY_W    = 7;
  localparam int COUNT_W   = 7;
  localparam int CFG_IDX_W = 2;

  // Item opcodes
  typedef enum logic [0:0] {
    OP_ADD_ROAD = 1'b0,
    OP_COMPUTE  = 1'b1
  } opcode_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK       = 2'd2;

  // Configuration reset values
  localparam logic [CITY_W-1:0] CITY_COUNT_RST = 7'd64;
  localparam logic [CITY_W-1:0] SOURCE_RST     = 7'd1;
  localparam logic [CITY_W-1:0] SINK_RST       = 7'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic add_road;   // road beat accepted, first direction written
    logic compute;    // compute beat accepted
    logic road_rev;   // second direction of the road
    logic bfs_init;   // start a search round
    logic deq;        // read queue head
    logic fetch;      // read rows of the dequeued node
    logic scan;       // enqueue one neighbor if any
    logic aug_start;  // start walking back from the sink
    logic aug_step;   // push flow over one arc
    logic clr_start;  // rewind clear row counter
    logic clr_step;   // clear one row of road and flow stores
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic range_ok;
    logic q_empty;
    logic cand_valid;
    logic cand_sink;
    logic at_src;
    logic clr_last;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/vertex_disjoint_path_count_top.sv -----
// Top level of the vertex-disjoint path counter.
// Instantiates vdpc_ctrl and vdpc_dp; depends on vdpc_pkg.
//
// After a road beat (opcode 0), busy_o is high for one cycle while the
// second direction of the road is written into the road row store. A
// compute beat (opcode 1) runs rounds of breadth-first search on the split
// graph; each round dequeues nodes, fetches their rows and scans their
// neighbors, and a found path is pushed by walking back from the sink. The
// count then appears on path_count_o for exactly one cycle with done_o
// high; it cannot be stalled. A clearing sweep, one row of the road and
// flow stores per cycle, follows each result and also runs after reset;
// busy_o stays high throughout.
// Configuration writes are always taken (cfg_ready_o tied high).
`default_nettype none

module vertex_disjoint_path_count_top #(
  parameter int MAX_CITIES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [0:0]                     opcode_i,
  input  logic [vdpc_pkg::CITY_W-1:0]    city_a_i,
  input  logic [vdpc_pkg::CITY_W-1:0]    city_b_i,
  output logic                           done_o,
  output logic [vdpc_pkg::COUNT_W-1:0]   path_count_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vdpc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vdpc_pkg::CITY_W-1:0]    cfg_data_i
);

  vdpc_pkg::cmd_t    cmd;
  vdpc_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  vdpc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i[0]),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  vdpc_dp #(
    .MAX_CITIES (MAX_CITIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .city_a_i     (city_a_i),
    .city_b_i     (city_b_i),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .path_count_o (path_count_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/vdpc_ctrl.sv -----
// Sequencer for the vertex-disjoint path counter: loads, search rounds,
// augmentation walks and the clearing sweep. Depends on vdpc_pkg.
`default_nettype none

module vdpc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              opcode_i,
  input  vdpc_pkg::status_t status_i,
  output vdpc_pkg::cmd_t    cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROAD,
    ST_INIT,
    ST_BFS_INIT,
    ST_DEQ,
    ST_FETCH,
    ST_SCAN,
    ST_AUG_START,
    ST_AUG,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   done_q;
  logic   accept;

  assign accept = start_i & ~busy_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == vdpc_pkg::OP_ADD_ROAD) begin
            cmd_o.add_road = 1'b1;
            state_d        = ST_ROAD;
          end else begin
            cmd_o.compute = 1'b1;
            state_d       = ST_INIT;
          end
        end
      end
      ST_ROAD: begin
        cmd_o.road_rev = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_INIT: begin
        state_d = status_i.range_ok ? ST_BFS_INIT : ST_EMIT;
      end
      ST_BFS_INIT: begin
        cmd_o.bfs_init = 1'b1;
        state_d        = ST_DEQ;
      end
      ST_DEQ: begin
        if (status_i.q_empty) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.deq = 1'b1;
          state_d   = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.cand_valid && status_i.cand_sink) state_d = ST_AUG_START;
        else if (!status_i.cand_valid) state_d = ST_DEQ;
      end
      ST_AUG_START: begin
        cmd_o.aug_start = 1'b1;
        state_d         = ST_AUG;
      end
      ST_AUG: begin
        cmd_o.aug_step = 1'b1;
        if (status_i.at_src) state_d = ST_BFS_INIT;
      end
      ST_EMIT: begin
        cmd_o.clr_start = 1'b1;
        state_d         = ST_CLEAR;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
      done_q  <= (state_d == ST_EMIT);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  // A result is always followed by the clearing sweep
  a_done_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> (busy_q && !done_q))
    else $error("result not followed by clear");

  // A result comes only from a failed search or an out-of-range endpoint
  a_done_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> ($past(state_q) == ST_INIT || $past(state_q) == ST_DEQ))
    else $error("result from unexpected state");

  // Busy is low only while waiting for a beat
  a_busy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (state_q != ST_IDLE))
    else $error("busy out of step with state");

endmodule

`default_nettype wire

// ----- rtl/core/vdpc_dp.sv -----
// Datapath of the vertex-disjoint path counter: configuration, road and flow
// row stores, search queue, predecessor store and augmentation. Depends on vdpc_pkg.
`default_nettype none

module vdpc_dp #(
  parameter int MAX_CITIES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vdpc_pkg::cmd_t                    cmd_i,
  output vdpc_pkg::status_t                 status_o,
  input  logic [vdpc_pkg::CITY_W-1:0]       city_a_i,
  input  logic [vdpc_pkg::CITY_W-1:0]       city_b_i,
  input  logic                              cfg_we_i,
  input  logic [vdpc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vdpc_pkg::CITY_W-1:0]       cfg_data_i,
  output logic [vdpc_pkg::COUNT_W-1:0]      path_count_o
);

  localparam int CW    = $clog2(MAX_CITIES);
  localparam int NW    = CW + 1;
  localparam int NSP   = 2 ** NW;
  localparam int HALF  = 2 ** CW;
  localparam int PTR_W = NW + 1;
  localparam int NCW   = $clog2(MAX_CITIES + 1);
  localparam logic [NW-1:0] QZERO = '0;

  // Configuration registers
  logic [vdpc_pkg::CITY_W-1:0] cc_q, src_q, snk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q  <= vdpc_pkg::CITY_COUNT_RST;
      src_q <= vdpc_pkg::SOURCE_RST;
      snk_q <= vdpc_pkg::SINK_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vdpc_pkg::CFG_CITY_COUNT: cc_q  <= cfg_data_i;
        vdpc_pkg::CFG_SOURCE:     src_q <= cfg_data_i;
        vdpc_pkg::CFG_SINK:       snk_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped city count, taken at the compute beat
  logic [31:0]    ccv;
  logic [NCW-1:0] n_q;
  logic [MAX_CITIES-1:0] lim;

  always_comb begin
    ccv = 32'(cc_q);
    if (ccv < 32'd2) ccv = 32'd2;
    if (ccv > 32'(MAX_CITIES)) ccv = 32'(MAX_CITIES);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.compute) n_q <= NCW'(ccv);
  end

  always_comb begin
    for (int b = 0; b < MAX_CITIES; b++) lim[b] = (32'(b) < 32'(n_q));
  end

  // Endpoints on the split graph
  logic          range_ok;
  logic [NW-1:0] src_node, snk_node;

  assign range_ok = (src_q != '0) && (32'(src_q) <= 32'(n_q)) &&
                    (snk_q != '0) && (32'(snk_q) <= 32'(n_q));
  assign src_node = {1'b0, CW'(32'(src_q) - 32'd1)};
  assign snk_node = {1'b1, CW'(32'(snk_q) - 32'd1)};

  // Road beat decode
  logic          item_ok;
  logic [CW-1:0] ca_idx, cb_idx;
  logic [CW-1:0] ra_q, rb_q;
  logic          road_ok_q;

  assign item_ok = (city_a_i != '0) && (32'(city_a_i) <= 32'(MAX_CITIES)) &&
                   (city_b_i != '0) && (32'(city_b_i) <= 32'(MAX_CITIES)) &&
                   (city_a_i != city_b_i);
  assign ca_idx  = CW'(32'(city_a_i) - 32'd1);
  assign cb_idx  = CW'(32'(city_b_i) - 32'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_road) begin
      ra_q      <= ca_idx;
      rb_q      <= cb_idx;
      road_ok_q <= item_ok;
    end
  end

  // Control registers: queue pointers, visited marks, node flow, count, clear row
  logic [PTR_W-1:0]           head_q, tail_q;
  logic [NSP-1:0]             vis_q;
  logic [MAX_CITIES-1:0]      nf_q;
  logic [vdpc_pkg::COUNT_W-1:0] cnt_q;
  logic [CW-1:0]              clr_q;

  // Stores
  logic [MAX_CITIES-1:0] road_mem [MAX_CITIES];
  logic [MAX_CITIES-1:0] flow_mem [MAX_CITIES];
  logic [CW-1:0]         fin_mem  [MAX_CITIES];
  logic [NW-1:0]         q_mem    [NSP];
  logic [NW-1:0]         pred_mem [NSP];

  logic [MAX_CITIES-1:0] road_row_q, flow_row_q;
  logic [CW-1:0]         fin_rd_q;
  logic [NW-1:0]         q_rd_q, pred_rd_q, u_q, v_q;

  // Neighbor search for the current node
  logic [CW-1:0]         ucity, nc, pb;
  logic                  u_in, found;
  logic [MAX_CITIES-1:0] mask;
  logic [NW-1:0]         cand;
  logic                  cand_valid;

  assign ucity = u_q[CW-1:0];
  assign u_in  = u_q[NW-1];

  always_comb begin
    for (int b = 0; b < MAX_CITIES; b++) begin
      mask[b] = ((road_row_q[b] & ~flow_row_q[b] & (CW'(b) != ucity)) |
                 ((CW'(b) == ucity) & nf_q[b])) & lim[b] & ~vis_q[HALF + b];
    end
    found = 1'b0;
    pb    = '0;
    for (int b = MAX_CITIES - 1; b >= 0; b--) begin
      if (mask[b]) begin
        found = 1'b1;
        pb    = CW'(b);
      end
    end
    // An in-node leads back to its own out-node, or to the feeder of its flow
    nc = nf_q[ucity] ? fin_rd_q : ucity;
    if (u_in) begin
      cand       = {1'b0, nc};
      cand_valid = ~vis_q[{1'b0, nc}];
    end else begin
      cand       = {1'b1, pb};
      cand_valid = found;
    end
  end

  // Augmentation over arc pred -> v
  logic [CW-1:0] ua, vb, aug_row, aug_col;
  logic          same, fwd, bwd, aug_wr, fin_wr;

  assign ua      = pred_rd_q[CW-1:0];
  assign vb      = v_q[CW-1:0];
  assign same    = (ua == vb);
  assign fwd     = ~pred_rd_q[NW-1] & v_q[NW-1];
  assign bwd     = pred_rd_q[NW-1] & ~v_q[NW-1];
  assign aug_wr  = cmd_i.aug_step & ~same & (fwd | bwd);
  assign fin_wr  = cmd_i.aug_step & ~same & fwd;
  assign aug_row = fwd ? ua : vb;
  assign aug_col = fwd ? vb : ua;

  // Road store
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) road_mem[clr_q] <= '0;
    else if (cmd_i.add_road && item_ok) road_mem[ca_idx][cb_idx] <= 1'b1;
    else if (cmd_i.road_rev && road_ok_q) road_mem[rb_q][ra_q] <= 1'b1;
    if (cmd_i.fetch) road_row_q <= road_mem[q_rd_q[CW-1:0]];
  end

  // Flow store, one bit per road arc
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) flow_mem[clr_q] <= '0;
    else if (aug_wr) flow_mem[aug_row][aug_col] <= fwd;
    if (cmd_i.fetch) flow_row_q <= flow_mem[q_rd_q[CW-1:0]];
  end

  // Feeder city of each loaded in-node
  always_ff @(posedge clk_i) begin
    if (fin_wr) fin_mem[vb] <= ua;
    if (cmd_i.fetch) fin_rd_q <= fin_mem[q_rd_q[CW-1:0]];
  end

  // Search queue
  always_ff @(posedge clk_i) begin
    if (cmd_i.bfs_init) q_mem[QZERO] <= src_node;
    else if (cmd_i.scan && cand_valid) q_mem[tail_q[NW-1:0]] <= cand;
    if (cmd_i.deq) q_rd_q <= q_mem[head_q[NW-1:0]];
  end

  // Predecessor store
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && cand_valid) pred_mem[cand] <= u_q;
    if (cmd_i.aug_start) pred_rd_q <= pred_mem[snk_node];
    else if (cmd_i.aug_step) pred_rd_q <= pred_mem[pred_rd_q];
  end

  // Current node and walk position
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) u_q <= q_rd_q;
    if (cmd_i.aug_start) v_q <= snk_node;
    else if (cmd_i.aug_step) v_q <= pred_rd_q;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      vis_q  <= '0;
      nf_q   <= '0;
      cnt_q  <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.bfs_init) begin
        head_q <= '0;
        tail_q <= PTR_W'(1);
        vis_q  <= NSP'(1) << src_node;
      end else begin
        if (cmd_i.deq) head_q <= head_q + PTR_W'(1);
        if (cmd_i.scan && cand_valid) begin
          tail_q      <= tail_q + PTR_W'(1);
          vis_q[cand] <= 1'b1;
        end
      end
      if (cmd_i.clr_step) nf_q <= '0;
      else if (cmd_i.aug_step && same && fwd) nf_q[vb] <= 1'b0;
      else if (cmd_i.aug_step && same && bwd) nf_q[ua] <= 1'b1;
      if (cmd_i.compute) cnt_q <= '0;
      else if (cmd_i.aug_step && status_o.at_src && cnt_q != '1)
        cnt_q <= cnt_q + vdpc_pkg::COUNT_W'(1);
      if (cmd_i.clr_start) clr_q <= '0;
      else if (cmd_i.clr_step) clr_q <= clr_q + CW'(1);
    end
  end

  // Status
  always_comb begin
    status_o            = '0;
    status_o.range_ok   = range_ok;
    status_o.q_empty    = (head_q == tail_q);
    status_o.cand_valid = cand_valid;
    status_o.cand_sink  = (cand == snk_node);
    status_o.at_src     = (pred_rd_q == src_node);
    status_o.clr_last   = (clr_q == CW'(MAX_CITIES - 1));
  end

  assign path_count_o = cnt_q;

  // Queue never reads past what was written
  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue head passed tail");

  // Each node is queued once at most
  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(tail_q) <= 32'(NSP))
    else $error("queue overflow");

  // The walk back only touches nodes the search reached
  a_walk_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.aug_step |-> vis_q[v_q])
    else $error("augmenting walk left the search tree");

endmodule

`default_nettype wire
